// ===== rtl/mi3_pkg.sv =====
// mi3_pkg: shared types and constants for the 3x3 adjugate matrix inverse
// used by every module under rtl/; depends on nothing
`default_nettype none

package mi3_pkg;

    localparam int NUM_ELEM = 9;
    localparam int EPS_W = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // operand indexes of each transposed cofactor c = a[x]*a[y] - a[u]*a[v]
    localparam int CF_X [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_Y [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_U [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CF_V [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    // per-word side info carried along the divider pipeline
    typedef struct packed {
        logic det_neg;
        logic singular;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/mi3_front.sv =====
// mi3_front: six-stage front end, cofactor products, cofactors, determinant
// and magnitudes; depends on mi3_pkg
`default_nettype none

module mi3_front
    import mi3_pkg::*;
#(
    parameter int E = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    output logic                 o_rdy,
    input  logic signed [E-1:0]  i_a [NUM_ELEM],
    output logic                 o_vld,
    input  logic                 i_rdy,
    output logic [3*E+2:0]       o_det_mag,
    output logic                 o_det_neg,
    output logic [2*E:0]         o_cmag [NUM_ELEM],
    output logic                 o_cneg [NUM_ELEM]
);

    localparam int CW = 2*E + 1;
    localparam int DW = 3*E + 3;
    localparam int PW = 2*E + 1;
    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_rdy;

    logic signed [2*E-1:0] r1_pa [NUM_ELEM];
    logic signed [2*E-1:0] r1_pb [NUM_ELEM];
    logic signed [E-1:0]   r1_a [3];
    logic signed [CW-1:0]  r2_c [NUM_ELEM];
    logic signed [E-1:0]   r2_a [3];
    logic signed [PW-1:0]  r3_lo [3];
    logic signed [PW-1:0]  r3_hi [3];
    logic signed [CW-1:0]  r3_c [NUM_ELEM];
    logic signed [DW-1:0]  r4_t [3];
    logic signed [CW-1:0]  r4_c [NUM_ELEM];
    logic signed [DW-1:0]  r5_det;
    logic signed [CW-1:0]  r5_c [NUM_ELEM];
    logic [DW-1:0]         r6_det_mag;
    logic                  r6_det_neg;
    logic [CW-1:0]         r6_cmag [NUM_ELEM];
    logic                  r6_cneg [NUM_ELEM];

    always_comb begin
        w_rdy[NS-1] = !r_vld[NS-1] || i_rdy;
        for (int s = NS-2; s >= 0; s--) begin
            w_rdy[s] = !r_vld[s] || w_rdy[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int k = 0; k < NUM_ELEM; k++) begin
                r1_pa[k] <= i_a[CF_X[k]] * i_a[CF_Y[k]];
                r1_pb[k] <= i_a[CF_U[k]] * i_a[CF_V[k]];
            end
            for (int i = 0; i < 3; i++) begin
                r1_a[i] <= i_a[i];
            end
        end
        if (w_rdy[1]) begin
            for (int k = 0; k < NUM_ELEM; k++) begin
                r2_c[k] <= CW'(r1_pa[k]) - CW'(r1_pb[k]);
            end
            r2_a <= r1_a;
        end
        // det partial products: cofactor split into signed high and unsigned low halves
        if (w_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r3_lo[i] <= r2_a[i] * $signed({1'b0, r2_c[3*i][E-1:0]});
                r3_hi[i] <= r2_a[i] * $signed(r2_c[3*i][CW-1:E]);
            end
            r3_c <= r2_c;
        end
        if (w_rdy[3]) begin
            for (int i = 0; i < 3; i++) begin
                r4_t[i] <= (DW'(r3_hi[i]) <<< E) + DW'(r3_lo[i]);
            end
            r4_c <= r3_c;
        end
        if (w_rdy[4]) begin
            r5_det <= r4_t[0] + r4_t[1] + r4_t[2];
            r5_c   <= r4_c;
        end
        if (w_rdy[5]) begin
            r6_det_neg <= r5_det[DW-1];
            r6_det_mag <= r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
            for (int k = 0; k < NUM_ELEM; k++) begin
                r6_cneg[k] <= r5_c[k][CW-1];
                r6_cmag[k] <= r5_c[k][CW-1] ? CW'(-r5_c[k]) : CW'(r5_c[k]);
            end
        end
    end

    assign o_rdy     = w_rdy[0];
    assign o_vld     = r_vld[NS-1];
    assign o_det_mag = r6_det_mag;
    assign o_det_neg = r6_det_neg;
    assign o_cmag    = r6_cmag;
    assign o_cneg    = r6_cneg;

endmodule

`default_nettype wire

// ===== rtl/mi3_div_head.sv =====
// mi3_div_head: singularity test and divider setup, high quotient overflow check
// and initial partial remainder per lane; depends on mi3_pkg
`default_nettype none

module mi3_div_head
    import mi3_pkg::*;
#(
    parameter int E = 32,
    parameter int F = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  logic [EPS_W-1:0]  i_eps,
    input  logic [3*E+2:0]    i_det_mag,
    input  logic              i_det_neg,
    input  logic [2*E:0]      i_cmag [NUM_ELEM],
    input  logic              i_cneg [NUM_ELEM],
    output logic              o_vld,
    input  logic              i_rdy,
    output t_side             o_side,
    output logic [3*E+2:0]    o_den,
    output logic [2*E:0]      o_cmag [NUM_ELEM],
    output logic              o_cneg [NUM_ELEM],
    output logic              o_big [NUM_ELEM],
    output logic [3*E+2:0]    o_rem [NUM_ELEM]
);

    localparam int CW = 2*E + 1;
    localparam int DW = 3*E + 3;
    localparam int NW = CW + 2*F;
    localparam int HW = NW - E - 1;
    localparam int XW0 = (HW > DW) ? HW : DW;
    localparam int XW1 = (EPS_W + 2*F > XW0) ? EPS_W + 2*F : XW0;
    localparam int XW = XW1 + 1;

    logic            r_vld;
    logic            w_rdy;
    t_side           r_side;
    logic [DW-1:0]   r_den;
    logic [CW-1:0]   r_cmag [NUM_ELEM];
    logic            r_cneg [NUM_ELEM];
    logic            r_big [NUM_ELEM];
    logic [DW-1:0]   r_rem [NUM_ELEM];

    logic [NW-1:0]   w_num [NUM_ELEM];
    logic [HW-1:0]   w_top [NUM_ELEM];
    logic            w_big [NUM_ELEM];
    logic [XW-1:0]   w_thr;
    logic            w_sing;

    always_comb begin
        w_thr  = XW'(i_eps) << (2*F);
        w_sing = (i_det_mag == '0) || (XW'(i_det_mag) < w_thr);
        for (int k = 0; k < NUM_ELEM; k++) begin
            w_num[k] = {i_cmag[k], {(2*F){1'b0}}};
            // quotient would need more than E+1 bits
            w_top[k] = w_num[k][NW-1:E+1];
            w_big[k] = XW'(w_top[k]) >= XW'(i_det_mag);
        end
    end

    assign w_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_side.det_neg  <= i_det_neg;
            r_side.singular <= w_sing;
            r_den           <= i_det_mag;
            for (int k = 0; k < NUM_ELEM; k++) begin
                r_cmag[k] <= i_cmag[k];
                r_cneg[k] <= i_cneg[k];
                r_big[k]  <= w_big[k];
                r_rem[k]  <= w_big[k] ? '0 : DW'(w_top[k]);
            end
        end
    end

    assign o_rdy  = w_rdy;
    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_den  = r_den;
    assign o_cmag = r_cmag;
    assign o_cneg = r_cneg;
    assign o_big  = r_big;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== rtl/mi3_div_step.sv =====
// mi3_div_step: one restoring division step, one quotient bit for all nine lanes
// depends on mi3_pkg
`default_nettype none

module mi3_div_step
    import mi3_pkg::*;
#(
    parameter int E   = 32,
    parameter int F   = 16,
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    output logic              o_rdy,
    input  t_side             i_side,
    input  logic [3*E+2:0]    i_den,
    input  logic [2*E:0]      i_cmag [NUM_ELEM],
    input  logic              i_cneg [NUM_ELEM],
    input  logic              i_big [NUM_ELEM],
    input  logic [3*E+2:0]    i_rem [NUM_ELEM],
    input  logic [E:0]        i_q [NUM_ELEM],
    output logic              o_vld,
    input  logic              i_rdy,
    output t_side             o_side,
    output logic [3*E+2:0]    o_den,
    output logic [2*E:0]      o_cmag [NUM_ELEM],
    output logic              o_cneg [NUM_ELEM],
    output logic              o_big [NUM_ELEM],
    output logic [3*E+2:0]    o_rem [NUM_ELEM],
    output logic [E:0]        o_q [NUM_ELEM]
);

    localparam int CW = 2*E + 1;
    localparam int DW = 3*E + 3;
    localparam bit HAS_BIT = (BIT >= 2*F);
    localparam int NB_IDX = HAS_BIT ? BIT - 2*F : 0;

    logic            r_vld;
    logic            w_rdy;
    t_side           r_side;
    logic [DW-1:0]   r_den;
    logic [CW-1:0]   r_cmag [NUM_ELEM];
    logic            r_cneg [NUM_ELEM];
    logic            r_big [NUM_ELEM];
    logic [DW-1:0]   r_rem [NUM_ELEM];
    logic [E:0]      r_q [NUM_ELEM];

    logic [DW:0]     w_t [NUM_ELEM];
    logic [DW:0]     w_d [NUM_ELEM];
    logic            w_ge [NUM_ELEM];
    logic [DW-1:0]   n_rem [NUM_ELEM];
    logic [E:0]      n_q [NUM_ELEM];

    always_comb begin
        for (int k = 0; k < NUM_ELEM; k++) begin
            // numerator is the cofactor magnitude shifted up by 2F, low bits zero
            w_t[k]   = {i_rem[k], HAS_BIT ? i_cmag[k][NB_IDX] : 1'b0};
            w_ge[k]  = w_t[k] >= {1'b0, i_den};
            w_d[k]   = w_t[k] - {1'b0, i_den};
            n_rem[k] = w_ge[k] ? w_d[k][DW-1:0] : w_t[k][DW-1:0];
            n_q[k]   = i_q[k];
            n_q[k][BIT] = w_ge[k];
        end
    end

    assign w_rdy = !r_vld || i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy) begin
            r_side <= i_side;
            r_den  <= i_den;
            r_cmag <= i_cmag;
            r_cneg <= i_cneg;
            r_big  <= i_big;
            r_rem  <= n_rem;
            r_q    <= n_q;
        end
    end

    assign o_rdy  = w_rdy;
    assign o_vld  = r_vld;
    assign o_side = r_side;
    assign o_den  = r_den;
    assign o_cmag = r_cmag;
    assign o_cneg = r_cneg;
    assign o_big  = r_big;
    assign o_rem  = r_rem;
    assign o_q    = r_q;

endmodule

`default_nettype wire

// ===== rtl/matrix3_inverse_adjugate_top.sv =====
// matrix3_inverse_adjugate_top: pipelined 3x3 fixed-point inverse by adjugate
// depends on mi3_pkg, mi3_front, mi3_div_head, mi3_div_step
//
// usage:
//   input channel i_valid/o_ready carries one matrix word, nine signed
//   elements i_a00..i_a22 in Q(ELEM_WIDTH-FRAC_BITS).FRAC_BITS, row major
//   output channel o_valid/i_ready carries the inverse o_r00..o_r22 plus the
//   singular and saturated flags
//   config channel i_cfg_valid/o_cfg_ready writes det_epsilon; always ready,
//   write only while the pipeline is empty
// stages from accept to o_valid:
//   six front stages, one divider setup stage, ELEM_WIDTH+1 restoring
//   division stages (one quotient bit each), one saturation/output stage
// throughput: one matrix per cycle while i_ready does not stall the output
// every stage has its own valid bit; a stage moves when it is empty or the
//   next stage moves, so when i_ready is low the pipeline fills its bubbles
//   and then holds, with nothing dropped or repeated
// reset: synchronous active low, empties the pipeline, det_epsilon back to 1
`default_nettype none

module matrix3_inverse_adjugate_top
    import mi3_pkg::*;
#(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [ELEM_WIDTH-1:0]  i_a00,
    input  logic signed [ELEM_WIDTH-1:0]  i_a01,
    input  logic signed [ELEM_WIDTH-1:0]  i_a02,
    input  logic signed [ELEM_WIDTH-1:0]  i_a10,
    input  logic signed [ELEM_WIDTH-1:0]  i_a11,
    input  logic signed [ELEM_WIDTH-1:0]  i_a12,
    input  logic signed [ELEM_WIDTH-1:0]  i_a20,
    input  logic signed [ELEM_WIDTH-1:0]  i_a21,
    input  logic signed [ELEM_WIDTH-1:0]  i_a22,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ELEM_WIDTH-1:0]  o_r00,
    output logic signed [ELEM_WIDTH-1:0]  o_r01,
    output logic signed [ELEM_WIDTH-1:0]  o_r02,
    output logic signed [ELEM_WIDTH-1:0]  o_r10,
    output logic signed [ELEM_WIDTH-1:0]  o_r11,
    output logic signed [ELEM_WIDTH-1:0]  o_r12,
    output logic signed [ELEM_WIDTH-1:0]  o_r20,
    output logic signed [ELEM_WIDTH-1:0]  o_r21,
    output logic signed [ELEM_WIDTH-1:0]  o_r22,
    output logic                          o_singular,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [EPS_W-1:0]              i_cfg_det_epsilon
);

    localparam int E  = ELEM_WIDTH;
    localparam int CW = 2*E + 1;
    localparam int DW = 3*E + 3;
    localparam int NSTEP = E + 1;
    localparam logic [E-1:0] ONE_Q =
        (FRAC_BITS < E-1) ? (E'(1) << FRAC_BITS) : ((E'(1) << (E-1)) - E'(1));
    localparam logic [E:0] LIM_NEG = (E+1)'(1) << (E-1);
    localparam logic [E:0] LIM_POS = LIM_NEG - (E+1)'(1);

    logic [EPS_W-1:0]      r_eps;

    logic signed [E-1:0]   w_a [NUM_ELEM];
    logic                  w_f_vld;
    logic                  w_f_rdy;
    logic [DW-1:0]         w_f_det_mag;
    logic                  w_f_det_neg;
    logic [CW-1:0]         w_f_cmag [NUM_ELEM];
    logic                  w_f_cneg [NUM_ELEM];

    logic                  w_vld [NSTEP+1];
    logic                  w_rdy [NSTEP+2];
    t_side                 w_side [NSTEP+1];
    logic [DW-1:0]         w_den [NSTEP+1];
    logic [CW-1:0]         w_cmag [NSTEP+1][NUM_ELEM];
    logic                  w_cneg [NSTEP+1][NUM_ELEM];
    logic                  w_big [NSTEP+1][NUM_ELEM];
    logic [DW-1:0]         w_rem [NSTEP+1][NUM_ELEM];
    logic [E:0]            w_q [NSTEP+1][NUM_ELEM];

    logic                  r_ovld;
    logic                  w_ordy;
    logic [E-1:0]          r_out [NUM_ELEM];
    logic                  r_sing;
    logic                  r_sat;
    logic [E-1:0]          n_out [NUM_ELEM];
    logic                  n_sat;
    logic                  w_neg;
    logic [E:0]            w_lim;
    logic [E:0]            w_mag;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_valid) begin
            r_eps <= i_cfg_det_epsilon;
        end
    end
    assign o_cfg_ready = 1'b1;

    assign w_a[0] = i_a00;
    assign w_a[1] = i_a01;
    assign w_a[2] = i_a02;
    assign w_a[3] = i_a10;
    assign w_a[4] = i_a11;
    assign w_a[5] = i_a12;
    assign w_a[6] = i_a20;
    assign w_a[7] = i_a21;
    assign w_a[8] = i_a22;

    mi3_front #(.E(E)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_valid),
        .o_rdy     (w_f_rdy),
        .i_a       (w_a),
        .o_vld     (w_f_vld),
        .i_rdy     (w_rdy[0]),
        .o_det_mag (w_f_det_mag),
        .o_det_neg (w_f_det_neg),
        .o_cmag    (w_f_cmag),
        .o_cneg    (w_f_cneg)
    );
    assign o_ready = w_f_rdy;

    mi3_div_head #(.E(E), .F(FRAC_BITS)) u_head (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_f_vld),
        .o_rdy     (w_rdy[0]),
        .i_eps     (r_eps),
        .i_det_mag (w_f_det_mag),
        .i_det_neg (w_f_det_neg),
        .i_cmag    (w_f_cmag),
        .i_cneg    (w_f_cneg),
        .o_vld     (w_vld[0]),
        .i_rdy     (w_rdy[1]),
        .o_side    (w_side[0]),
        .o_den     (w_den[0]),
        .o_cmag    (w_cmag[0]),
        .o_cneg    (w_cneg[0]),
        .o_big     (w_big[0]),
        .o_rem     (w_rem[0])
    );

    for (genvar k = 0; k < NUM_ELEM; k++) begin : g_q0
        assign w_q[0][k] = '0;
    end

    // last division stage is held by the output register
    assign w_rdy[NSTEP+1] = w_ordy;

    // quotient bits from msb down, one stage each
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
        mi3_div_step #(.E(E), .F(FRAC_BITS), .BIT(E - j)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[j]),
            .o_rdy   (w_rdy[j+1]),
            .i_side  (w_side[j]),
            .i_den   (w_den[j]),
            .i_cmag  (w_cmag[j]),
            .i_cneg  (w_cneg[j]),
            .i_big   (w_big[j]),
            .i_rem   (w_rem[j]),
            .i_q     (w_q[j]),
            .o_vld   (w_vld[j+1]),
            .i_rdy   (w_rdy[j+2]),
            .o_side  (w_side[j+1]),
            .o_den   (w_den[j+1]),
            .o_cmag  (w_cmag[j+1]),
            .o_cneg  (w_cneg[j+1]),
            .o_big   (w_big[j+1]),
            .o_rem   (w_rem[j+1]),
            .o_q     (w_q[j+1])
        );
    end

    // sign, saturation and identity substitution
    always_comb begin
        n_sat = 1'b0;
        w_neg = 1'b0;
        w_lim = '0;
        w_mag = '0;
        for (int k = 0; k < NUM_ELEM; k++) begin
            // an overflowed quotient is nonzero even when its low bits are zero
            w_neg = (w_cneg[NSTEP][k] ^ w_side[NSTEP].det_neg)
                    && (w_big[NSTEP][k] || (w_q[NSTEP][k] != '0));
            w_lim = w_neg ? LIM_NEG : LIM_POS;
            w_mag = w_q[NSTEP][k];
            if (w_big[NSTEP][k] || (w_mag > w_lim)) begin
                w_mag = w_lim;
                n_sat = 1'b1;
            end
            n_out[k] = w_neg ? E'(-w_mag) : w_mag[E-1:0];
            if (w_side[NSTEP].singular) begin
                n_out[k] = (k == 0 || k == 4 || k == 8) ? ONE_Q : '0;
            end
        end
        if (w_side[NSTEP].singular) begin
            n_sat = 1'b0;
        end
    end

    assign w_ordy = !r_ovld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_ordy) begin
            r_ovld <= w_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ordy) begin
            r_out  <= n_out;
            r_sing <= w_side[NSTEP].singular;
            r_sat  <= n_sat;
        end
    end

    assign o_valid     = r_ovld;
    assign o_r00       = r_out[0];
    assign o_r01       = r_out[1];
    assign o_r02       = r_out[2];
    assign o_r10       = r_out[3];
    assign o_r11       = r_out[4];
    assign o_r12       = r_out[5];
    assign o_r20       = r_out[6];
    assign o_r21       = r_out[7];
    assign o_r22       = r_out[8];
    assign o_singular  = r_sing;
    assign o_saturated = r_sat;

    a_sing_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> !o_saturated)
        else $error("saturated flag set on singular word");

    a_sing_offdiag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_r01 == '0) && (o_r10 == '0) && (o_r21 == '0))
        else $error("singular word has nonzero off-diagonal");

    a_sing_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> (o_r00 == o_r11) && (o_r11 == o_r22))
        else $error("singular word diagonal mismatch");

endmodule

`default_nettype wire

// ===== test/tb_checker.sv =====
// tb_checker: watches the matrix, result and epsilon channels of the 3x3 inverse
// depends on mi3_pkg; predicts each inverse exactly and compares per field
`timescale 1ns / 100ps

module tb_checker
    import mi3_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [31:0]        i_mat [NUM_ELEM],
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  logic [31:0]        i_inv [NUM_ELEM],
    input  logic               i_singular,
    input  logic               i_saturated,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [EPS_W-1:0]   i_cfg_eps,
    output int                 o_fails,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_singulars,
    output int                 o_clamped
);

    typedef struct {
        logic [31:0] inv [NUM_ELEM];
        logic        singular;
        logic        saturated;
    } t_inverse;

    // transposed cofactor c = a[x]*a[y] - a[u]*a[v]
    localparam int PX [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PY [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int PU [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int PV [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    t_inverse        expected_inverses [$];
    logic [EPS_W-1:0] epsilon;

    function automatic t_inverse invert_matrix(input logic [31:0] m [NUM_ELEM],
                                               input logic [EPS_W-1:0] eps);
        t_inverse          res;
        logic signed [127:0] a [NUM_ELEM];
        logic signed [127:0] cof [NUM_ELEM];
        logic signed [127:0] det;
        logic [127:0]        det_mag, num, quo, lim, thr;
        logic                neg;
        for (int i = 0; i < NUM_ELEM; i++) a[i] = $signed(m[i]);
        for (int i = 0; i < NUM_ELEM; i++)
            cof[i] = a[PX[i]] * a[PY[i]] - a[PU[i]] * a[PV[i]];
        det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
        det_mag = det < 0 ? -det : det;
        thr = 128'(eps) << 32;
        res.saturated = 1'b0;
        if (det_mag == 0 || det_mag < thr) begin
            for (int i = 0; i < NUM_ELEM; i++)
                res.inv[i] = (i == 0 || i == 4 || i == 8) ? 32'h0001_0000 : 32'h0;
            res.singular = 1'b1;
            return res;
        end
        res.singular = 1'b0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            num = (cof[i] < 0 ? -cof[i] : cof[i]);
            num = num << 32;
            quo = num / det_mag;
            neg = ((cof[i] < 0) != (det < 0)) && quo != 0;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (quo > lim) begin
                quo = lim;
                res.saturated = 1'b1;
            end
            res.inv[i] = neg ? 32'(-quo) : quo[31:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at %0t: got %h expected %h", field, $time, got, want);
        o_fails++;
    endtask

    initial begin
        o_fails = 0;
        o_results = 0;
        o_singulars = 0;
        o_clamped = 0;
        epsilon = EPS_RESET;
    end

    assign o_pending = expected_inverses.size();

    always @(posedge i_clk) begin
        t_inverse want;
        if (!i_rst_n) begin
            epsilon = EPS_RESET;
            expected_inverses.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_inverses.size() == 0) begin
                    $display("unexpected result word at %0t", $time);
                    o_fails++;
                end else begin
                    want = expected_inverses.pop_front();
                    for (int i = 0; i < NUM_ELEM; i++)
                        if (i_inv[i] !== want.inv[i])
                            report_mismatch($sformatf("r%0d%0d", i / 3, i % 3),
                                            i_inv[i], want.inv[i]);
                    if (i_singular !== want.singular)
                        report_mismatch("singular", i_singular, want.singular);
                    if (i_saturated !== want.saturated)
                        report_mismatch("saturated", i_saturated, want.saturated);
                    o_results++;
                    if (want.singular) o_singulars++;
                    if (want.saturated) o_clamped++;
                end
            end
            if (i_valid && i_ready_in)
                expected_inverses.push_back(invert_matrix(i_mat, epsilon));
            if (i_cfg_valid && i_cfg_ready)
                epsilon = i_cfg_eps;
        end
    end

endmodule

// ===== test/tb_top.sv =====
// tb_top: stimulus and verdict for matrix3_inverse_adjugate_top
// depends on mi3_pkg, the block under rtl/ and tb_checker
`timescale 1ns / 100ps

module tb_top;
    import mi3_pkg::*;

    localparam int LATENCY = 41;
    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [31:0]       mat [NUM_ELEM];
    logic              o_valid;
    logic              i_ready;
    logic [31:0]       inv [NUM_ELEM];
    logic              o_singular;
    logic              o_saturated;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [EPS_W-1:0]  i_cfg_det_epsilon;
    int                fails, pending, results, singulars, clamped;
    int                idle_pct;
    int                cycles;
    int                sent;

    matrix3_inverse_adjugate_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_a00(mat[0]), .i_a01(mat[1]), .i_a02(mat[2]),
        .i_a10(mat[3]), .i_a11(mat[4]), .i_a12(mat[5]),
        .i_a20(mat[6]), .i_a21(mat[7]), .i_a22(mat[8]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_r00(inv[0]), .o_r01(inv[1]), .o_r02(inv[2]),
        .o_r10(inv[3]), .o_r11(inv[4]), .o_r12(inv[5]),
        .o_r20(inv[6]), .o_r21(inv[7]), .o_r22(inv[8]),
        .o_singular(o_singular), .o_saturated(o_saturated),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_det_epsilon(i_cfg_det_epsilon)
    );

    tb_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_mat(mat), .i_res_valid(o_valid), .i_res_ready(i_ready), .i_inv(inv),
        .i_singular(o_singular), .i_saturated(o_saturated),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_eps(i_cfg_det_epsilon),
        .o_fails(fails), .o_pending(pending), .o_results(results),
        .o_singulars(singulars), .o_clamped(clamped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk)
        if (i_rst_n) i_ready <= ($urandom_range(99) >= idle_pct);

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_matrix(input logic [31:0] m [NUM_ELEM]);
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        mat = m;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic write_epsilon(input logic [EPS_W-1:0] eps);
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_det_epsilon = eps;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_elem(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
            2: return 32'($signed($urandom_range(64)) - 32);
            default: return 32'($signed($urandom_range(1 << 12)) - (1 << 11));
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] m [NUM_ELEM];
        int          kind;
        kind = $urandom_range(9);
        for (int i = 0; i < NUM_ELEM; i++) begin
            case (kind)
                0, 1: m[i] = rand_elem(0);
                2: m[i] = rand_elem(2);
                3: m[i] = rand_elem(3);
                // well-conditioned: unit-ish diagonal with small off-diagonal
                4, 5, 6: m[i] = (i % 4 == 0) ? rand_elem(1) + 32'h0001_0000
                                             : rand_elem(3);
                7: m[i] = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
                default: m[i] = rand_elem(1);
            endcase
        end
        // occasionally copy a row so the determinant is exactly zero
        if ($urandom_range(15) == 0)
            for (int i = 0; i < 3; i++) m[6 + i] = m[3 + i];
        send_matrix(m);
    endtask

    task automatic send_diag(input logic [31:0] d0, input logic [31:0] d1,
                             input logic [31:0] d2, input logic [31:0] off);
        logic [31:0] m [NUM_ELEM];
        for (int i = 0; i < NUM_ELEM; i++) m[i] = off;
        m[0] = d0;
        m[4] = d1;
        m[8] = d2;
        send_matrix(m);
    endtask

    initial begin
        logic [31:0] m [NUM_ELEM];
        cycles = 0;
        sent = 0;
        idle_pct = 24;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_det_epsilon = '0;
        for (int i = 0; i < NUM_ELEM; i++) mat[i] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset epsilon
        send_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_diag(32'h0, 32'h0, 32'h0, 32'h0);
        send_diag(32'h0000_0001, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0);
        send_diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
        send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send_diag(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
        send_diag(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_diag(32'h0002_0000, 32'hfffe_0000, 32'h0004_0000, 32'h0000_8000);
        send_diag(32'h0000_0100, 32'hffff_ff00, 32'h0000_0001, 32'h0);
        send_diag(32'h0000_0010, 32'h0000_0010, 32'h0000_0010, 32'h0);
        for (int i = 0; i < NUM_ELEM; i++) m[i] = 32'(i + 1) << 16;
        send_matrix(m);
        for (int i = 0; i < NUM_ELEM; i++) m[i] = 32'h8000_0000;
        send_matrix(m);
        for (int i = 0; i < NUM_ELEM; i++) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
        send_matrix(m);

        // zero epsilon: only an exactly zero determinant is singular
        write_epsilon(16'd0);
        send_diag(32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_diag(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0);
        send_diag(32'h0000_0002, 32'h0000_0002, 32'h0000_0002, 32'h0);
        // largest epsilon
        write_epsilon(16'hffff);
        send_diag(32'h0001_0000, 32'h0001_0000, 32'h0000_ffff, 32'h0);
        send_diag(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0);
        send_diag(32'h0001_0000, 32'h0001_0000, 32'hffff_0001, 32'h0);

        // random phases under several thresholds
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_epsilon(16'd1);
                1: write_epsilon(16'd0);
                2: write_epsilon(16'($urandom_range(16'hffff)));
                3: write_epsilon(16'hffff);
                default: write_epsilon(16'($urandom_range(255)));
            endcase
            for (int k = 0; k < 280; k++) begin
                idle_pct = (ph == 2 && k >= 60 && k < 200) ? 0 : 24;
                // sender holds off until the pipeline drains
                if (k == 140) begin
                    i_valid = 1'b0;
                    while (pending != 0) @(negedge i_clk);
                end
                send_random();
            end
        end
        idle_pct = 24;
        i_valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("sent %0d matrices, checked %0d inverses", sent, results);
        $display("%0d came back singular and %0d had clamped elements", singulars, clamped);
        if (fails == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_head.sv
rtl/mi3_div_step.sv
rtl/matrix3_inverse_adjugate_top.sv
test/tb_checker.sv
test/tb_top.sv
